>>> src/uuidg_pkg.sv
// Shared types and constants for the time-based UUID generator.
`timescale 1ns / 1ps

package uuidg_pkg;

  // Field widths.
  localparam int unsigned SecsW    = 34;
  localparam int unsigned MicrosW  = 20;
  localparam int unsigned SeqW     = 13;
  localparam int unsigned NodeW    = 48;
  localparam int unsigned SubTickW = 4;
  localparam int unsigned CountW   = 60;
  localparam int unsigned TicksW   = 24;
  localparam int unsigned ProdW    = SecsW + TicksW;
  localparam int unsigned LowW     = 24;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 48;

  // Request queue geometry.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  // Time base: 100 ns units per second, and the 1582 to 1970 offset.
  localparam logic [TicksW-1:0] TicksPerSec = 24'd10000000;
  localparam logic [CountW-1:0] EpochOffset = 60'h1B21DD213814000;

  // Version nibble and variant field of the packed UUID.
  localparam logic [3:0] VersionTime = 4'h1;
  localparam logic [2:0] VariantRfc  = 3'b100;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] CfgNodeAddr = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgInitSeq  = 2'd1;

  // One classified request, handed from the front to the back.
  typedef struct packed {
    logic [SecsW-1:0]    secs;
    logic [MicrosW-1:0]  micros;
    logic [SubTickW-1:0] sub_tick;
    logic [SeqW-1:0]     seq;
  } req_t;

endpackage

>>> src/uuidg_front.sv
// Front end: accepts time readings, tracks clock sequence and sub-tick state.
`timescale 1ns / 1ps

module uuidg_front #(
  parameter int unsigned MAX_SUB_TICKS = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [uuidg_pkg::SecsW-1:0]   time_seconds_i,
  input  logic [uuidg_pkg::MicrosW-1:0] time_micros_i,
  input  logic [uuidg_pkg::SeqW-1:0]    init_seq_i,
  input  logic                      queue_full_i,
  output logic                      push_o,
  output uuidg_pkg::req_t           push_data_o
);
  import uuidg_pkg::*;

  localparam logic [SubTickW-1:0] SubTickMax = SubTickW'(MAX_SUB_TICKS);

  logic [SecsW-1:0]    last_secs_q,   last_secs_d;
  logic [MicrosW-1:0]  last_micros_q, last_micros_d;
  logic [SeqW-1:0]     seq_q,         seq_d;
  logic [SubTickW-1:0] sub_tick_q,    sub_tick_d;
  logic                started_q,     started_d;

  logic accept;
  logic earlier;
  logic same;
  logic emit;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Compare the new reading against the stored one.
  assign earlier = (time_seconds_i < last_secs_q) ||
                   ((time_seconds_i == last_secs_q) && (time_micros_i < last_micros_q));
  assign same    = (time_seconds_i == last_secs_q) && (time_micros_i == last_micros_q);

  // Classify the request and work out the next state.
  always_comb begin
    last_secs_d   = last_secs_q;
    last_micros_d = last_micros_q;
    seq_d         = seq_q;
    sub_tick_d    = sub_tick_q;
    started_d     = started_q;
    emit          = 1'b1;
    if (!started_q) begin
      seq_d      = init_seq_i;
      sub_tick_d = '0;
      started_d  = 1'b1;
    end else if (earlier) begin
      seq_d      = seq_q + 1'b1;
      sub_tick_d = '0;
    end else if (same) begin
      if (sub_tick_q >= SubTickMax) begin
        emit = 1'b0;
      end else begin
        sub_tick_d = sub_tick_q + 1'b1;
      end
    end else begin
      sub_tick_d = '0;
    end
    if (emit) begin
      last_secs_d   = time_seconds_i;
      last_micros_d = time_micros_i;
    end
  end

  assign push_o               = accept && emit;
  assign push_data_o.secs     = time_seconds_i;
  assign push_data_o.micros   = time_micros_i;
  assign push_data_o.sub_tick = sub_tick_d;
  assign push_data_o.seq      = seq_d;

  // State only moves when a request produces a UUID.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_secs_q   <= '0;
      last_micros_q <= '0;
      seq_q         <= '0;
      sub_tick_q    <= '0;
      started_q     <= 1'b0;
    end else if (accept && emit) begin
      last_secs_q   <= last_secs_d;
      last_micros_q <= last_micros_d;
      seq_q         <= seq_d;
      sub_tick_q    <= sub_tick_d;
      started_q     <= started_d;
    end
  end

endmodule

>>> src/uuidg_fifo.sv
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps

module uuidg_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  uuidg_pkg::req_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output uuidg_pkg::req_t pop_data_o
);
  import uuidg_pkg::*;

  req_t            entries_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;

  logic do_push;
  logic do_pop;

  assign full_o     = (count_q == CntW'(QueueDepth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entries_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> src/uuidg_back.sv
// Back end: forms the 60-bit timestamp and packs the UUID in two stages.
`timescale 1ns / 1ps

module uuidg_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         queue_empty_i,
  input  uuidg_pkg::req_t              queue_data_i,
  output logic                         pop_o,
  input  logic [uuidg_pkg::NodeW-1:0]  node_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [63:0]                  uuid_upper_o,
  output logic [63:0]                  uuid_lower_o
);
  import uuidg_pkg::*;

  logic             s1_valid_q;
  logic [ProdW-1:0] prod_q;
  logic [LowW-1:0]  low_q;
  logic [SeqW-1:0]  seq_q;

  logic             out_valid_q;
  logic [63:0]      upper_q, upper_d;
  logic [63:0]      lower_q, lower_d;

  logic             out_take;
  logic             s1_load;
  logic [ProdW-1:0] prod_d;
  logic [LowW-1:0]  low_d;
  logic [CountW-1:0] count;

  // Flow control: each stage moves when the one after it has room.
  assign out_take = !out_valid_q || out_ready_i;
  assign s1_load  = !s1_valid_q || out_take;
  assign pop_o    = !queue_empty_i && s1_load;

  // Stage 1: seconds scaled to 100 ns units, micros times ten plus sub-tick.
  assign prod_d = {{TicksW{1'b0}}, queue_data_i.secs} * {{SecsW{1'b0}}, TicksPerSec};
  assign low_d  = {1'b0, queue_data_i.micros, 3'b000} +
                  {3'b000, queue_data_i.micros, 1'b0} +
                  {{(LowW-SubTickW){1'b0}}, queue_data_i.sub_tick};

  // Stage 2: add the epoch offset and pack the fields.
  assign count   = {{(CountW-ProdW){1'b0}}, prod_q} +
                   {{(CountW-LowW){1'b0}}, low_q} + EpochOffset;
  assign upper_d = {count[31:0], count[47:32], VersionTime, count[59:48]};
  assign lower_d = {VariantRfc, seq_q, node_i};

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_q <= prod_d;
      low_q  <= low_d;
      seq_q  <= queue_data_i.seq;
    end
    if (s1_valid_q && out_take) begin
      upper_q <= upper_d;
      lower_q <= lower_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= pop_o;
      end
      if (out_take) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign uuid_upper_o = upper_q;
  assign uuid_lower_o = lower_q;

endmodule

>>> src/uuid_v1_generator.sv
// Top level of the time-based (version 1) UUID generator.
`timescale 1ns / 1ps
//
// Usage: each request on the input channel (in_valid_i / in_ready_o) carries
// one time reading, seconds since 1970 and microseconds within the second.
// The block answers with a version-1 UUID on the output channel
// (out_valid_o / out_ready_i), split into the upper and lower 64 bits.
// A request whose reading repeats the previous one more often than the
// sub-tick limit allows is taken but gives no UUID; the caller retries.
// The node address and initial clock sequence are written through the
// configuration port (cfg_we_i, cfg_addr_i, cfg_wdata_i) while idle.
// Throughput: one request per cycle while the queue is not full; the front
// end settles the sequence state as the request is taken, and the back
// end's multiply and add stages are fully pipelined. A two-entry queue
// sits between the two parts.
// When the receiver stalls, the output register holds its UUID, the back
// end fills, the queue fills, and then in_ready_o drops.
// Reset clears the configuration registers, the stored reading, the clock
// sequence and sub-tick state, and empties the queue and pipeline.

module uuid_v1_generator #(
  parameter int unsigned MAX_SUB_TICKS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [uuidg_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [uuidg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [uuidg_pkg::SecsW-1:0]     time_seconds_i,
  input  logic [uuidg_pkg::MicrosW-1:0]   time_micros_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [63:0]                     uuid_upper_o,
  output logic [63:0]                     uuid_lower_o
);
  import uuidg_pkg::*;

  logic [NodeW-1:0] node_q;
  logic [SeqW-1:0]  init_seq_q;

  logic push;
  req_t push_data;
  logic queue_full;
  logic queue_empty;
  logic pop;
  req_t pop_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q     <= '0;
      init_seq_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgNodeAddr: node_q     <= cfg_wdata_i[NodeW-1:0];
        CfgInitSeq:  init_seq_q <= cfg_wdata_i[SeqW-1:0];
        default: ;
      endcase
    end
  end

  uuidg_front #(
    .MAX_SUB_TICKS(MAX_SUB_TICKS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .time_seconds_i(time_seconds_i),
    .time_micros_i (time_micros_i),
    .init_seq_i    (init_seq_q),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  uuidg_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (queue_full),
    .pop_i      (pop),
    .empty_o    (queue_empty),
    .pop_data_o (pop_data)
  );

  uuidg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .queue_empty_i(queue_empty),
    .queue_data_i (pop_data),
    .pop_o        (pop),
    .node_i       (node_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .uuid_upper_o (uuid_upper_o),
    .uuid_lower_o (uuid_lower_o)
  );

endmodule

>>> src/uuidg_assert.sv
// Port-level assertions for the UUID generator, bound to the top level.
`timescale 1ns / 1ps

module uuidg_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] uuid_upper_o,
  input logic [63:0] uuid_lower_o
);
  import uuidg_pkg::*;

  // A stalled UUID stays in place until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(uuid_upper_o) && $stable(uuid_lower_o))
    else $error("UUID changed or dropped while stalled");

  // Every UUID carries the time-based version nibble.
  a_version: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> uuid_upper_o[15:12] == VersionTime)
    else $error("UUID version nibble is wrong");

  // Every UUID carries the standard variant bits.
  a_variant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> uuid_lower_o[63:61] == VariantRfc)
    else $error("UUID variant bits are wrong");

endmodule

bind uuid_v1_generator uuidg_assert u_assert (.*);
